// File: rtl/jss_pkg.sv
// jss_pkg: shared types and constants for the jtag scan sequencer
// item structs, tap phase codes and the sequencer state record
// no dependencies
package jss_pkg;

   localparam int DR_BYTES    = 4;
   localparam int RESET_TICKS = 5;
   localparam int DR_BITS     = DR_BYTES * 8;
   localparam int IR_MAX      = 32;
   localparam int CAP_W       = 32;
   localparam int IR_LEN_W    = 6;
   localparam int IR_LEN_RST  = 4;

   // counter must reach the largest terminal count among the three loops
   localparam int CNT_MAX = (DR_BITS > IR_MAX)
                            ? ((DR_BITS > RESET_TICKS) ? DR_BITS : RESET_TICKS)
                            : ((IR_MAX > RESET_TICKS) ? IR_MAX : RESET_TICKS);
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   // right shift that lands the first read bit at bit 0 for short data registers
   localparam int CAP_ALIGN = (DR_BITS < CAP_W) ? (CAP_W - DR_BITS) : 0;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_HEAD = 4'd1,
      PH_RTI_A    = 4'd2,
      PH_SELDR_A  = 4'd3,
      PH_SELIR    = 4'd4,
      PH_CAPIR    = 4'd5,
      PH_SHIR     = 4'd6,
      PH_IRBITS   = 4'd7,
      PH_UPDIR    = 4'd8,
      PH_RTI_B    = 4'd9,
      PH_SELDR    = 4'd10,
      PH_CAPDR    = 4'd11,
      PH_SHDR     = 4'd12,
      PH_READ     = 4'd13,
      PH_RST_TAIL = 4'd14
   } phase_type;

   typedef struct packed {
      logic              start_req;
      logic              mode;
      logic [31:0]       instruction;
      logic              tdo;
   } req_type;

   typedef struct packed {
      logic              tck_pulse;
      logic              tms;
      logic              tdi;
      logic              trst_n;
      logic              busy_res;
      logic              done_res;
      logic [CAP_W-1:0]  captured;
   } rsp_type;

   typedef struct packed {
      phase_type         phase;
      logic [CNT_W-1:0]  bit_count;
      logic [31:0]       instr_shift;
      logic [CAP_W-1:0]  capture_shift;
      logic              scan_mode;
      logic              parked_high;
   } state_type;

endpackage

// File: rtl/jss_step.sv
// jss_step: one tck period of the tap sequencer, purely combinational
// takes the current state, one item and the ir length; gives next state and result
// depends on jss_pkg
module jss_step (
   input  jss_pkg::state_type          cur_state,
   input  jss_pkg::req_type            req_item,
   input  logic [jss_pkg::IR_LEN_W-1:0] ir_length,
   output jss_pkg::state_type          nxt_state,
   output jss_pkg::rsp_type            rsp_item
);

   jss_pkg::state_type                work;
   logic [jss_pkg::CNT_W-1:0]         cnt_inc;
   logic [jss_pkg::IR_LEN_W-1:0]      eff_len;
   logic                              tms;
   logic                              tdi;
   logic                              done;

   // length 0 acts as 1, anything above the max acts as the max
   always_comb begin
      if (ir_length == '0) begin
         eff_len = jss_pkg::IR_LEN_W'(1);
      end else if (ir_length > jss_pkg::IR_LEN_W'(jss_pkg::IR_MAX)) begin
         eff_len = jss_pkg::IR_LEN_W'(jss_pkg::IR_MAX);
      end else begin
         eff_len = ir_length;
      end
   end

   always_comb begin
      work = cur_state;
      tms  = 1'b0;
      tdi  = 1'b0;
      done = 1'b0;
      cnt_inc = '0;
      rsp_item = '0;

      if (cur_state.phase == jss_pkg::PH_IDLE && !req_item.start_req) begin
         rsp_item.tck_pulse = 1'b0;
         rsp_item.tms       = cur_state.parked_high;
         rsp_item.tdi       = cur_state.parked_high;
         rsp_item.trst_n    = cur_state.parked_high;
         rsp_item.busy_res  = 1'b0;
         rsp_item.done_res  = 1'b0;
         rsp_item.captured  = cur_state.capture_shift;
      end else begin
         // start item latches the request and runs the first reset tick
         if (cur_state.phase == jss_pkg::PH_IDLE) begin
            work.scan_mode     = req_item.mode;
            work.instr_shift   = req_item.instruction;
            work.capture_shift = '0;
            work.bit_count     = '0;
            work.phase         = jss_pkg::PH_RST_HEAD;
         end
         cnt_inc = work.bit_count + jss_pkg::CNT_W'(1);

         unique case (work.phase)
            jss_pkg::PH_RST_HEAD: begin
               tms = 1'b1;
               work.bit_count = cnt_inc;
               if (cnt_inc >= jss_pkg::CNT_W'(jss_pkg::RESET_TICKS)) begin
                  work.bit_count = '0;
                  work.phase     = jss_pkg::PH_RTI_A;
               end
            end
            jss_pkg::PH_RTI_A: begin
               work.phase = work.scan_mode ? jss_pkg::PH_SELDR_A : jss_pkg::PH_SELDR;
            end
            jss_pkg::PH_SELDR_A: begin
               tms = 1'b1;
               work.phase = jss_pkg::PH_SELIR;
            end
            jss_pkg::PH_SELIR: begin
               tms = 1'b1;
               work.phase = jss_pkg::PH_CAPIR;
            end
            jss_pkg::PH_CAPIR: begin
               work.phase = jss_pkg::PH_SHIR;
            end
            jss_pkg::PH_SHIR: begin
               work.phase     = jss_pkg::PH_IRBITS;
               work.bit_count = '0;
            end
            jss_pkg::PH_IRBITS: begin
               tdi = work.instr_shift[0];
               work.instr_shift = work.instr_shift >> 1;
               work.bit_count   = cnt_inc;
               if (cnt_inc >= jss_pkg::CNT_W'(eff_len)) begin
                  tms = 1'b1;
                  work.bit_count = '0;
                  work.phase     = jss_pkg::PH_UPDIR;
               end
            end
            jss_pkg::PH_UPDIR: begin
               tms = 1'b1;
               work.phase = jss_pkg::PH_RTI_B;
            end
            jss_pkg::PH_RTI_B: begin
               work.phase = jss_pkg::PH_SELDR;
            end
            jss_pkg::PH_SELDR: begin
               tms = 1'b1;
               work.phase = jss_pkg::PH_CAPDR;
            end
            jss_pkg::PH_CAPDR: begin
               work.phase = jss_pkg::PH_SHDR;
            end
            jss_pkg::PH_SHDR: begin
               work.phase     = jss_pkg::PH_READ;
               work.bit_count = '0;
            end
            jss_pkg::PH_READ: begin
               work.capture_shift = {req_item.tdo, work.capture_shift[jss_pkg::CAP_W-1:1]};
               work.bit_count     = cnt_inc;
               if (cnt_inc >= jss_pkg::CNT_W'(jss_pkg::DR_BITS)) begin
                  tms = 1'b1;
                  work.capture_shift = work.capture_shift >> jss_pkg::CAP_ALIGN;
                  work.bit_count     = '0;
                  work.phase         = jss_pkg::PH_RST_TAIL;
               end
            end
            jss_pkg::PH_RST_TAIL: begin
               tms = 1'b1;
               work.bit_count = cnt_inc;
               if (cnt_inc >= jss_pkg::CNT_W'(jss_pkg::RESET_TICKS)) begin
                  work.bit_count   = '0;
                  done             = 1'b1;
                  work.parked_high = 1'b1;
                  work.phase       = jss_pkg::PH_IDLE;
               end
            end
            default: begin
               work.phase     = jss_pkg::PH_IDLE;
               work.bit_count = '0;
            end
         endcase

         rsp_item.tck_pulse = 1'b1;
         rsp_item.tms       = tms;
         rsp_item.tdi       = tdi;
         rsp_item.trst_n    = 1'b1;
         rsp_item.busy_res  = 1'b1;
         rsp_item.done_res  = done;
         rsp_item.captured  = work.capture_shift;
      end
   end

   assign nxt_state = work;

endmodule

// File: rtl/jtag_scan_sequencer_unit.sv
// jtag_scan_sequencer_unit: top level of the jtag tap master sequencer
// input register, jss_step tick logic and result register
// depends on jss_pkg and jss_step
//
//   port group   dir   handshake              payload
//   req_*        in    req_valid / req_ready  req_data (jss_pkg::req_type)
//   rsp_*        out   rsp_valid / rsp_ready  rsp_data (jss_pkg::rsp_type)
//   csr_*        in    csr_wr_en              csr_wr_data (ir_length)
//
// one item per clock unless a stalled result holds it; an accepted item goes from the input
// register through the tick logic into the result register, which it leaves on rsp_ready.
// synchronous active-high reset clears both valid flags, the tap state and ir_length (4).
// a stalled result holds the result register; one more item can wait in the input
// register, and req_ready drops only while both registers are full and rsp_ready is low.
module jtag_scan_sequencer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  jss_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output jss_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [jss_pkg::IR_LEN_W-1:0]  csr_wr_data
);

   logic                           in_valid_ff;
   jss_pkg::req_type               in_data_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   jss_pkg::rsp_type               out_data_ff;
   jss_pkg::state_type             state_ff;
   jss_pkg::state_type             state_in;
   jss_pkg::rsp_type               step_rsp;
   logic [jss_pkg::IR_LEN_W-1:0]   ir_length_ff;
   logic                           advance;

   // held item moves into the result register when that register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   jss_step u_step (
      .cur_state (state_ff),
      .req_item  (in_data_ff),
      .ir_length (ir_length_ff),
      .nxt_state (state_in),
      .rsp_item  (step_rsp)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         ir_length_ff <= jss_pkg::IR_LEN_W'(jss_pkg::IR_LEN_RST);
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            ir_length_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
